// File: hdl/nhe_pkg.sv
// Shared types and constants for the NAND Hamming ECC sector check.
package nhe_pkg;

   localparam int SECTOR_BYTES = 256;
   localparam int POS_WIDTH = $clog2(SECTOR_BYTES);
   localparam int ECC_WIDTH = 24;
   // syndrome bits 23..2 hold exactly this many ones for a single flipped data bit
   localparam int CORRECTABLE_ONES = 11;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_CORRECTED = 2'd1,
      STATUS_FAILED = 2'd2
   } status_type;

   typedef struct packed {
      logic [5:0] column;
      logic [7:0] line_true;
      logic [7:0] line_inverted;
   } parity_type;

   typedef struct packed {
      status_type status;
      logic [7:0] error_byte;
      logic [2:0] error_bit;
      logic [ECC_WIDTH-1:0] computed_ecc;
   } result_type;

endpackage

// File: hdl/nhe_req_if.sv
// Byte request channel: one sector byte per transfer.
interface nhe_req_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;
   logic last_byte;
   logic [nhe_pkg::ECC_WIDTH-1:0] stored_ecc;

   modport source (output valid, data_byte, last_byte, stored_ecc, input ready);
   modport sink (input valid, data_byte, last_byte, stored_ecc, output ready);
endinterface

// File: hdl/nhe_rsp_if.sv
// Check result channel: one transfer per sector.
interface nhe_rsp_if;
   logic valid;
   logic ready;
   nhe_pkg::status_type status;
   logic [7:0] error_byte;
   logic [2:0] error_bit;
   logic [nhe_pkg::ECC_WIDTH-1:0] computed_ecc;

   modport source (output valid, status, error_byte, error_bit, computed_ecc, input ready);
   modport sink (input valid, status, error_byte, error_bit, computed_ecc, output ready);
endinterface

// File: hdl/nand_hamming_ecc_check.sv
// Hamming ECC check of one 256-byte NAND sector against its 3-byte spare-area code.
// req_chan carries one sector byte per transfer in address order; last_byte marks
// the final byte, and stored_ecc is sampled with that byte. rsp_chan carries one
// result per sector: status, error byte offset and bit, and the computed code.
// Bytes enter an input register, then the parity accumulators; a last byte also
// passes through the syndrome decoder into the result register.
// Throughput: one byte per cycle, set by the input register feeding the accumulators,
// except that a last byte waits while a result is pending. Result path: the input
// register takes the last byte at its transfer, and the result register loads from it
// once it is free, which raises rsp_chan.valid.
// Reset clears the input and result valid flags, the parities and the byte
// position; the next byte accepted is byte zero of a sector.
// When the receiver stalls, the result register holds its result; ordinary bytes
// keep flowing, but the next last byte waits in the input register and
// req_chan.ready drops until the pending result is taken.
// A sector that ends early is coded over the bytes seen; without a last byte the
// position wraps at 256 and the parities keep accumulating.
module nand_hamming_ecc_check (
   input logic        clock,
   input logic        reset,
   nhe_req_if.sink    req_chan,
   nhe_rsp_if.source  rsp_chan
);

   logic in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic in_last_ff;
   logic [nhe_pkg::ECC_WIDTH-1:0] in_stored_ff;
   logic advance;
   logic rsp_valid_ff, rsp_valid_in;
   nhe_pkg::result_type rsp_result_ff, decoded;
   nhe_pkg::parity_type parity_next;

   // a last byte needs the result register free, other bytes always move on
   assign advance = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   nhe_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .data_byte   (in_data_ff),
      .last_byte   (in_last_ff),
      .parity_next (parity_next)
   );

   nhe_decode u_decode (
      .parity     (parity_next),
      .stored_ecc (in_stored_ff),
      .result     (decoded)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_data_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.last_byte;
         in_stored_ff <= req_chan.stored_ecc;
      end
      if (advance && in_last_ff) begin
         rsp_result_ff <= decoded;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_result_ff.status;
   assign rsp_chan.error_byte = rsp_result_ff.error_byte;
   assign rsp_chan.error_bit = rsp_result_ff.error_bit;
   assign rsp_chan.computed_ecc = rsp_result_ff.computed_ecc;

   a_last_loads_result: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> rsp_valid_ff)
      else $error("last byte did not produce a result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(rsp_result_ff))
      else $error("pending result lost or overwritten");

   a_clean_location: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_result_ff.status != nhe_pkg::STATUS_CORRECTED
      |-> rsp_result_ff.error_byte == '0 && rsp_result_ff.error_bit == '0)
      else $error("error location set without a corrected status");

   a_ecc_low_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_result_ff.computed_ecc[1:0] == 2'b11)
      else $error("computed code low bits not set");

endmodule

// File: hdl/nhe_accum.sv
// Column and line parity accumulator with byte position counter.
module nhe_accum (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   output nhe_pkg::parity_type parity_next
);

   logic [nhe_pkg::POS_WIDTH-1:0] pos_ff, pos_in;
   nhe_pkg::parity_type parity_ff, parity_in;
   logic [5:0] col_bits;
   logic odd_byte;
   logic [7:0] pos_byte;

   assign pos_byte = 8'(pos_ff);

   always_comb begin
      col_bits[0] = ^(data_byte & 8'h55);
      col_bits[1] = ^(data_byte & 8'haa);
      col_bits[2] = ^(data_byte & 8'h33);
      col_bits[3] = ^(data_byte & 8'hcc);
      col_bits[4] = ^(data_byte & 8'h0f);
      col_bits[5] = ^(data_byte & 8'hf0);
      odd_byte = ^data_byte;

      parity_next.column = parity_ff.column ^ col_bits;
      parity_next.line_true = parity_ff.line_true ^ (odd_byte ? pos_byte : 8'h00);
      parity_next.line_inverted = parity_ff.line_inverted ^ (odd_byte ? ~pos_byte : 8'h00);

      parity_in = parity_ff;
      pos_in = pos_ff;
      if (step) begin
         if (last_byte) begin
            // sector done: start the next one from scratch
            parity_in = '0;
            pos_in = '0;
         end else begin
            parity_in = parity_next;
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= '0;
         pos_ff <= '0;
      end else begin
         parity_ff <= parity_in;
         pos_ff <= pos_in;
      end
   end

   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      step && last_byte |=> parity_ff == '0 && pos_ff == '0)
      else $error("accumulator not cleared after last byte");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      step && !last_byte |=> pos_ff == $past(pos_ff) + 1'b1)
      else $error("byte position did not advance");

endmodule

// File: hdl/nhe_decode.sv
// Builds the 3-byte code, the syndrome and the error location.
module nhe_decode (
   input  nhe_pkg::parity_type            parity,
   input  logic [nhe_pkg::ECC_WIDTH-1:0] stored_ecc,
   output nhe_pkg::result_type           result
);

   logic [7:0] ecc0, ecc1, ecc2;
   logic [nhe_pkg::ECC_WIDTH-1:0] code, syn;
   logic [4:0] ones;
   logic [7:0] ebyte;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         ecc0[7-2*k] = ~parity.line_true[7-k];
         ecc0[6-2*k] = ~parity.line_inverted[7-k];
         ecc1[7-2*k] = ~parity.line_true[3-k];
         ecc1[6-2*k] = ~parity.line_inverted[3-k];
      end
      ecc2 = {~parity.column, 2'b11};
      code = {ecc0, ecc1, ecc2};
      syn = stored_ecc ^ code;
      ones = 5'($countones(syn[23:2]));
      for (int k = 0; k < 8; k++) begin
         ebyte[k] = syn[9+2*k];
      end

      result.computed_ecc = code;
      result.error_byte = '0;
      result.error_bit = '0;
      if (syn == '0) begin
         result.status = nhe_pkg::STATUS_OK;
      end else if (ones == 5'(nhe_pkg::CORRECTABLE_ONES)) begin
         result.status = nhe_pkg::STATUS_CORRECTED;
         result.error_byte = ebyte;
         result.error_bit = {syn[7], syn[5], syn[3]};
      end else begin
         result.status = nhe_pkg::STATUS_FAILED;
      end
   end

endmodule

// File: tb/nand_hamming_ecc_check_tb.sv
// Self-checking testbench for the NAND sector Hamming ECC check.
`timescale 1ns / 1ps

module nand_hamming_ecc_check_tb;

   localparam int RANDOM_BYTES = 1150;
   localparam int MAX_GAP = 9;
   localparam int RX_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT = 100000;

   typedef logic [7:0] byte_q_type[$];

   typedef struct packed {
      logic [nhe_pkg::POS_WIDTH-1:0] pos;
      nhe_pkg::parity_type par;
   } sector_state_type;

   typedef struct {
      logic [7:0] data_byte;
      logic last_byte;
      logic [nhe_pkg::ECC_WIDTH-1:0] stored_ecc;
      int gap;
      bit hold_rx;
      bit drain_first;
   } byte_xfer_type;

   typedef enum {
      DMG_NONE,
      DMG_DATA_BIT,
      DMG_CODE_BIT,
      DMG_TWO_BITS,
      DMG_RANDOM_CODE,
      DMG_SPARE_BITS
   } damage_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   nhe_req_if req_chan ();
   nhe_rsp_if rsp_chan ();

   byte_xfer_type byte_stream[$];
   nhe_pkg::result_type result_due[$];
   sector_state_type sector_acc = '0;

   bit byte_taken = 1'b0;
   bit result_taken = 1'b0;
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;
   bit rx_eager = 1'b0;
   int rx_hold_left = 0;
   int gap_waited = 0;
   int stall_left = 0;
   int cycle_count = 0;
   int errors = 0;
   int bytes_accepted = 0;
   int sectors_checked = 0;
   int ok_count = 0;
   int fixed_count = 0;
   int failed_count = 0;

   nand_hamming_ecc_check dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   // Fold one byte into the running column and line parities.
   function automatic sector_state_type fold_byte(sector_state_type s, logic [7:0] b);
      sector_state_type n;
      n = s;
      n.par.column ^= {^(b & 8'hF0), ^(b & 8'h0F), ^(b & 8'hCC),
                       ^(b & 8'h33), ^(b & 8'hAA), ^(b & 8'h55)};
      if (^b) begin
         n.par.line_true ^= s.pos;
         n.par.line_inverted ^= ~s.pos;
      end
      n.pos = s.pos + 1'b1;
      return n;
   endfunction

   // Inverted 3-byte code: true/inverted line parity interleaved, column parity in ecc2.
   function automatic logic [nhe_pkg::ECC_WIDTH-1:0] ecc_of_parity(nhe_pkg::parity_type p);
      logic [7:0] hi;
      logic [7:0] lo;
      int k;
      for (k = 0; k < 4; k++) begin
         hi[7-2*k] = p.line_true[7-k];
         hi[6-2*k] = p.line_inverted[7-k];
         lo[7-2*k] = p.line_true[3-k];
         lo[6-2*k] = p.line_inverted[3-k];
      end
      return {~hi, ~lo, ~p.column, 2'b11};
   endfunction

   function automatic logic [nhe_pkg::ECC_WIDTH-1:0] code_of_bytes(byte_q_type bytes);
      sector_state_type s;
      int i;
      s = '0;
      for (i = 0; i < bytes.size(); i++)
         s = fold_byte(s, bytes[i]);
      return ecc_of_parity(s.par);
   endfunction

   function automatic nhe_pkg::result_type check_sector(nhe_pkg::parity_type p,
                                                       logic [nhe_pkg::ECC_WIDTH-1:0] stored);
      nhe_pkg::result_type r;
      logic [nhe_pkg::ECC_WIDTH-1:0] syn;
      int k;
      r = '0;
      r.computed_ecc = ecc_of_parity(p);
      syn = stored ^ r.computed_ecc;
      if (syn == '0) begin
         r.status = nhe_pkg::STATUS_OK;
      end else if ($countones(syn[23:2]) == nhe_pkg::CORRECTABLE_ONES) begin
         r.status = nhe_pkg::STATUS_CORRECTED;
         for (k = 0; k < 8; k++)
            r.error_byte[k] = syn[9+2*k];
         r.error_bit = {syn[7], syn[5], syn[3]};
      end else begin
         r.status = nhe_pkg::STATUS_FAILED;
      end
      return r;
   endfunction

   task automatic push_sector(byte_q_type sent, logic [nhe_pkg::ECC_WIDTH-1:0] stored,
                              bit bursty, bit hold_rx, bit drain_first);
      byte_xfer_type x;
      int i;
      for (i = 0; i < sent.size(); i++) begin
         x.data_byte = sent[i];
         x.last_byte = (i == sent.size() - 1);
         // stored_ecc is ignored on ordinary bytes, so put noise there
         x.stored_ecc = x.last_byte ? stored : 24'($urandom_range(0, 24'hFFFFFF));
         x.gap = bursty ? 0 : $urandom_range(0, MAX_GAP);
         x.hold_rx = hold_rx && i == 0;
         x.drain_first = drain_first && i == 0;
         byte_stream.push_back(x);
      end
   endtask

   task automatic queue_sector(byte_q_type clean, damage_type damage, bit bursty,
                               bit hold_rx, bit drain_first);
      byte_q_type sent;
      logic [nhe_pkg::ECC_WIDTH-1:0] stored;
      int p1;
      int p2;
      int b1;
      int b2;
      sent = clean;
      stored = code_of_bytes(clean);
      p1 = $urandom_range(0, clean.size() - 1);
      p2 = $urandom_range(0, clean.size() - 1);
      b1 = $urandom_range(0, 7);
      b2 = $urandom_range(0, 7);
      case (damage)
         DMG_DATA_BIT: begin
            sent[p1] = sent[p1] ^ (8'd1 << b1);
         end
         DMG_CODE_BIT: begin
            stored = stored ^ (24'd1 << $urandom_range(0, nhe_pkg::ECC_WIDTH - 1));
         end
         DMG_TWO_BITS: begin
            if (p1 == p2 && b1 == b2)
               b2 = (b1 + 1) % 8;
            sent[p1] = sent[p1] ^ (8'd1 << b1);
            sent[p2] = sent[p2] ^ (8'd1 << b2);
         end
         DMG_RANDOM_CODE: begin
            stored = 24'($urandom_range(0, 24'hFFFFFF));
         end
         DMG_SPARE_BITS: begin
            // the two low code bits are not counted by the syndrome rule
            stored = stored ^ 24'($urandom_range(1, 3));
         end
         default: begin
         end
      endcase
      push_sector(sent, stored, bursty, hold_rx, drain_first);
   endtask

   initial begin : power_on
      repeat (3) @(negedge clock);
      reset <= 1'b0;
   end

   initial begin : stimulus
      byte_q_type clean;
      damage_type damage;
      int sector_idx;
      int random_bytes;
      int len;
      int pick;
      int i;
      bit hold_block;

      // directed: field extremes, every damage kind but a random code, short sectors
      push_sector('{8'h00}, 24'h000000, 1'b0, 1'b0, 1'b0);
      queue_sector('{8'h00}, DMG_NONE, 1'b1, 1'b0, 1'b0);
      queue_sector('{8'hFF}, DMG_NONE, 1'b0, 1'b0, 1'b0);
      queue_sector('{8'hA5}, DMG_DATA_BIT, 1'b0, 1'b0, 1'b0);
      queue_sector('{8'h5A}, DMG_CODE_BIT, 1'b1, 1'b0, 1'b0);
      queue_sector('{8'h3C}, DMG_SPARE_BITS, 1'b0, 1'b0, 1'b0);
      queue_sector('{8'hFF, 8'h00, 8'h81}, DMG_DATA_BIT, 1'b1, 1'b0, 1'b0);
      queue_sector('{8'h12, 8'h34, 8'h56, 8'h78}, DMG_TWO_BITS, 1'b0, 1'b0, 1'b0);
      queue_sector('{8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h00},
                   DMG_DATA_BIT, 1'b0, 1'b0, 1'b0);
      push_sector('{8'hC3}, 24'hFFFFFF, 1'b0, 1'b0, 1'b0);

      random_bytes = 0;
      sector_idx = 0;
      while (random_bytes < RANDOM_BYTES) begin
         // sectors 10..21: tiny back-to-back sectors while the receiver holds off
         hold_block = sector_idx >= 10 && sector_idx < 22;
         if (sector_idx == 0)
            len = $urandom_range(nhe_pkg::SECTOR_BYTES + 1, nhe_pkg::SECTOR_BYTES + 64);
         else if (hold_block)
            len = $urandom_range(1, 3);
         else if ($urandom_range(0, 19) == 0)
            len = nhe_pkg::SECTOR_BYTES;
         else
            len = $urandom_range(1, 24);

         clean.delete();
         for (i = 0; i < len; i++) begin
            pick = $urandom_range(0, 15);
            clean.push_back(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
         end

         pick = $urandom_range(0, 9);
         damage = pick < 3 ? DMG_NONE :
                  pick < 6 ? DMG_DATA_BIT :
                  pick == 6 ? DMG_CODE_BIT :
                  pick == 7 ? DMG_TWO_BITS :
                  pick == 8 ? DMG_RANDOM_CODE : DMG_SPARE_BITS;

         queue_sector(clean, damage, hold_block || $urandom_range(0, 2) == 0,
                      sector_idx == 10, sector_idx == 0 || sector_idx == 30);
         random_bytes += len;
         sector_idx++;
      end

      while (byte_stream.size() != 0 || req_chan.valid !== 1'b0 || result_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d bytes in %0d sectors: %0d clean, %0d corrected, %0d uncorrectable",
               bytes_accepted, sectors_checked, ok_count, fixed_count, failed_count);
      $display("short, full and wrapped sectors; %0d mismatches", errors);
      if (errors == 0) begin
         $display("nand_hamming_ecc_check regression: pass");
      end else begin
         $display("nand_hamming_ecc_check regression: fail");
      end
      $finish;
   end

   // Request side: predict on every transfer, offer the next byte at the falling edge.
   always @(posedge clock) begin : byte_accept
      byte_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         sector_acc = fold_byte(sector_acc, req_chan.data_byte);
         bytes_accepted++;
         if (req_chan.last_byte) begin
            result_due.push_back(check_sector(sector_acc.par, req_chan.stored_ecc));
            sector_acc = '0;
         end
      end
   end

   always @(negedge clock) begin : byte_driver
      byte_xfer_type next_xfer;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || byte_taken) begin
         if (byte_stream.size() == 0 ||
             (byte_stream[0].drain_first && result_due.size() != 0)) begin
            req_chan.valid <= 1'b0;
         end else if (gap_waited < byte_stream[0].gap) begin
            gap_waited++;
            req_chan.valid <= 1'b0;
         end else begin
            next_xfer = byte_stream.pop_front();
            req_chan.data_byte <= next_xfer.data_byte;
            req_chan.last_byte <= next_xfer.last_byte;
            req_chan.stored_ecc <= next_xfer.stored_ecc;
            req_chan.valid <= 1'b1;
            hold_request <= next_xfer.hold_rx;
            gap_waited = 0;
         end
      end
   end

   // Long receiver hold-off, started once by a flagged byte.
   always @(negedge clock) begin : rx_hold_timer
      if (hold_request && !hold_done) begin
         rx_hold_left <= RX_HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (rx_hold_left != 0) begin
         rx_hold_left <= rx_hold_left - 1;
      end
   end

   always @(negedge clock) begin : rsp_acceptor
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (result_taken) begin
            if ($urandom_range(0, 3) == 0)
               rx_eager = !rx_eager;
            stall_left = rx_eager ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (rx_hold_left != 0 || stall_left != 0) begin
            if (rx_hold_left == 0 && rsp_chan.valid)
               stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      nhe_pkg::result_type want;
      result_taken <= !reset && rsp_chan.valid && rsp_chan.ready;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (result_due.size() == 0) begin
            $display("%0t: unexpected result: status %0d byte %0d bit %0d ecc %06h", $time,
                     rsp_chan.status, rsp_chan.error_byte, rsp_chan.error_bit,
                     rsp_chan.computed_ecc);
            errors++;
         end else begin
            want = result_due.pop_front();
            sectors_checked++;
            case (want.status)
               nhe_pkg::STATUS_OK: ok_count++;
               nhe_pkg::STATUS_CORRECTED: fixed_count++;
               default: failed_count++;
            endcase
            if (rsp_chan.status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status,
                        rsp_chan.status);
               errors++;
            end
            if (rsp_chan.error_byte !== want.error_byte) begin
               $display("%0t: error_byte expected %0d got %0d", $time, want.error_byte,
                        rsp_chan.error_byte);
               errors++;
            end
            if (rsp_chan.error_bit !== want.error_bit) begin
               $display("%0t: error_bit expected %0d got %0d", $time, want.error_bit,
                        rsp_chan.error_bit);
               errors++;
            end
            if (rsp_chan.computed_ecc !== want.computed_ecc) begin
               $display("%0t: computed_ecc expected %06h got %06h", $time, want.computed_ecc,
                        rsp_chan.computed_ecc);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d bytes queued, %0d results pending",
                  $time, cycle_count, byte_stream.size(), result_due.size());
         $display("nand_hamming_ecc_check regression: fail");
         $finish;
      end
   end

endmodule
